>>> design/odc_pkg.sv
// odc_pkg: widths, constants, month table and control structs for the
// ordinal day to calendar date block; no dependencies
package odc_pkg;

   localparam int DaysW = 15;
   localparam int YearW = 14;
   localparam int DoyW  = 9;
   localparam int MonW  = 4;
   localparam int DomW  = 5;
   localparam int ModW  = 5;
   localparam int QuotW = 10;
   localparam int ProdW = 27;

   // floor(y / 25) == (y * 5243) >> 17 holds exactly for every 14-bit y
   localparam logic [12:0] Recip25     = 13'd5243;
   localparam int          RecipShift  = 17;
   localparam logic [ModW-1:0] Mod25Last = 5'd24;

   localparam logic [DoyW-1:0] YearLen     = 9'd365;
   localparam logic [DoyW-1:0] LeapYearLen = 9'd366;
   localparam logic [DomW-1:0] LeapFebLen  = 5'd29;

   localparam logic [MonW-1:0] MonJan    = 4'd0;
   localparam logic [MonW-1:0] MonFeb    = 4'd1;
   localparam logic [MonW-1:0] LastMonth = 4'd11;

   // entries above december are never reached
   localparam logic [DomW-1:0] MonthDays [16] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
      5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
   };

   typedef struct packed {
      logic load;
      logic mod_quot;
      logic mod_rem;
      logic year_step;
      logic month_init;
      logic month_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic year_more;
      logic month_more;
      logic out_free;
   } dp_status_type;

   function automatic logic [DomW-1:0] month_len(input logic [MonW-1:0] mon,
                                                 input logic leap);
      logic [DomW-1:0] len;
      len = MonthDays[mon];
      if (leap && (mon == MonFeb)) begin
         len = LeapFebLen;
      end
      return len;
   endfunction

endpackage

>>> design/odc_if.sv
// odc request and response channel interfaces (valid/ready plus payload)
// depends on odc_pkg for field widths
interface odc_req_if;
   import odc_pkg::*;
   logic             valid;
   logic             ready;
   logic [DaysW-1:0] total_days;
   logic [YearW-1:0] start_year;

   modport source (output valid, output total_days, output start_year, input ready);
   modport sink   (input valid, input total_days, input start_year, output ready);
endinterface

interface odc_rsp_if;
   import odc_pkg::*;
   logic             valid;
   logic             ready;
   logic [YearW-1:0] norm_year;
   logic [DoyW-1:0]  day_of_year;
   logic [MonW-1:0]  month_num;
   logic [DomW-1:0]  day_of_month;
   logic             leap_flag;

   modport source (output valid, output norm_year, output day_of_year, output month_num,
                   output day_of_month, output leap_flag, input ready);
   modport sink   (input valid, input norm_year, input day_of_year, input month_num,
                   input day_of_month, input leap_flag, output ready);
endinterface

>>> design/odc_ctrl.sv
// odc_ctrl: sequencing state machine for the date conversion
// depends on odc_pkg (command and status structs)
module odc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output odc_pkg::dp_cmd_type    cmd,
   input  odc_pkg::dp_status_type status
);
   import odc_pkg::*;

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StQuot  = 3'd1;
   localparam logic [2:0] StRem   = 3'd2;
   localparam logic [2:0] StYear  = 3'd3;
   localparam logic [2:0] StMonth = 3'd4;
   localparam logic [2:0] StDone  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StQuot;
            end
         end
         StQuot: begin
            cmd.mod_quot = 1'b1;
            state_in     = StRem;
         end
         StRem: begin
            cmd.mod_rem = 1'b1;
            state_in    = StYear;
         end
         StYear: begin
            if (status.year_more) begin
               cmd.year_step = 1'b1;
            end else begin
               cmd.month_init = 1'b1;
               state_in       = StMonth;
            end
         end
         StMonth: begin
            if (status.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   assign req_ready = (state_ff == StIdle);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result written while output register still full");

   a_load_then_quot: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.mod_quot)
      else $error("modulo setup did not follow a load");

   a_month_after_year: assert property (@(posedge clock) disable iff (reset)
      cmd.month_init |=> (state_ff == StMonth))
      else $error("month phase not entered after year phase");

endmodule

>>> design/odc_dp.sv
// odc_dp: year carry and month split datapath with output register
// depends on odc_pkg (widths, month table, command and status structs)
module odc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  odc_pkg::dp_cmd_type           cmd,
   output odc_pkg::dp_status_type        status,
   input  logic [odc_pkg::DaysW-1:0]     total_days,
   input  logic [odc_pkg::YearW-1:0]     start_year,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [odc_pkg::YearW-1:0]     norm_year,
   output logic [odc_pkg::DoyW-1:0]      day_of_year,
   output logic [odc_pkg::MonW-1:0]      month_num,
   output logic [odc_pkg::DomW-1:0]      day_of_month,
   output logic                          leap_flag
);
   import odc_pkg::*;

   logic [YearW-1:0] year_ff, year_in;
   logic [DaysW-1:0] count_ff, count_in;
   logic [QuotW-1:0] quot_ff, quot_in;
   logic [ModW-1:0]  m25_ff, m25_in;
   logic [MonW-1:0]  mon_ff, mon_in;
   logic [DoyW-1:0]  rem_ff, rem_in;

   logic [YearW-1:0] oyear_ff;
   logic [DoyW-1:0]  odoy_ff;
   logic [MonW-1:0]  omon_ff;
   logic [DomW-1:0]  odom_ff;
   logic             oleap_ff;
   logic             ovalid_ff, ovalid_in;

   logic [ProdW-1:0] prod;
   logic [YearW-1:0] quot_x25;
   logic             leap;
   logic [DoyW-1:0]  ylen;
   logic [DomW-1:0]  mlen;
   logic [YearW-1:0] year_inc;

   // leap: divisible by 4, and not by 100 unless by 400 (100 = 4*25, 400 = 16*25)
   assign leap = (year_ff[1:0] == 2'd0) && ((m25_ff != '0) || (year_ff[3:0] == 4'd0));
   assign ylen = leap ? LeapYearLen : YearLen;
   assign mlen = month_len(mon_ff, leap);
   assign year_inc = year_ff + 1'b1;

   assign prod     = ProdW'(year_ff) * ProdW'(Recip25);
   assign quot_x25 = YearW'({quot_ff, 4'b0} + {1'b0, quot_ff, 3'b0} + {4'b0, quot_ff});

   always_comb begin
      year_in  = year_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      m25_in   = m25_ff;
      mon_in   = mon_ff;
      rem_in   = rem_ff;
      if (cmd.load) begin
         year_in  = start_year;
         count_in = total_days;
      end
      if (cmd.mod_quot) begin
         quot_in = prod[RecipShift +: QuotW];
      end
      if (cmd.mod_rem) begin
         m25_in = ModW'(year_ff - quot_x25);
      end
      if (cmd.year_step) begin
         count_in = count_ff - DaysW'(ylen);
         year_in  = year_inc;
         // year counter wraps to 0, which is a multiple of 25
         if ((year_inc == '0) || (m25_ff == Mod25Last)) begin
            m25_in = '0;
         end else begin
            m25_in = m25_ff + 1'b1;
         end
      end
      if (cmd.month_init) begin
         rem_in = count_ff[DoyW-1:0];
         mon_in = MonJan;
      end
      if (cmd.month_step) begin
         rem_in = rem_ff - DoyW'(mlen);
         mon_in = mon_ff + 1'b1;
      end
   end

   assign status.year_more  = (count_ff > DaysW'(ylen));
   assign status.month_more = (rem_ff > DoyW'(mlen)) && (mon_ff != LastMonth);
   assign status.out_free   = !ovalid_ff || out_ready;

   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.emit) begin
         ovalid_in = 1'b1;
      end else if (out_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      count_ff <= count_in;
      quot_ff  <= quot_in;
      m25_ff   <= m25_in;
      mon_ff   <= mon_in;
      rem_ff   <= rem_in;
      if (cmd.emit) begin
         oyear_ff <= year_ff;
         odoy_ff  <= count_ff[DoyW-1:0];
         omon_ff  <= mon_ff + 1'b1;
         odom_ff  <= rem_ff[DomW-1:0];
         oleap_ff <= leap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   assign out_valid    = ovalid_ff;
   assign norm_year    = oyear_ff;
   assign day_of_year  = odoy_ff;
   assign month_num    = omon_ff;
   assign day_of_month = odom_ff;
   assign leap_flag    = oleap_ff;

   a_mod25_range: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |-> (m25_ff <= Mod25Last))
      else $error("year residue mod 25 out of range");

   a_year_step_count: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |-> (count_ff > DaysW'(YearLen)))
      else $error("year carried with count below a year length");

   a_month_step_range: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (mon_ff < LastMonth))
      else $error("month step past december");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> ovalid_ff)
      else $error("output valid not set after result capture");

endmodule

>>> design/ordinal_day_to_calendar_date.sv
// ordinal_day_to_calendar_date: top level of the day count to date converter
// depends on odc_pkg, odc_if, odc_ctrl and odc_dp
//
// usage
//  - req channel (valid/ready) carries one word: total_days (one-based count)
//    and start_year; the word is taken when valid and ready are both high
//  - rsp channel (valid/ready) returns one word per request: norm_year,
//    day_of_year, month_num, day_of_month and leap_flag
//  - the time from acceptance to rsp valid grows with Y, the number of whole
//    years carried out of the count (at most 89 for a 15-bit count), and with
//    M, the month index (0 to 11)
//  - the year loop carries one year per cycle through one subtract and
//    compare, and the month loop takes one month per cycle, which sets the rate
//  - the quot and rem steps find start_year mod 25 with a reciprocal multiply; the
//    residue then follows the year counter and drives the leap test
//  - one item is worked on at a time, so a new word is not taken until the
//    previous one is done; the next word is accepted as soon as the previous
//    result has moved into the output register
//  - if the receiver stalls, the result stays in the output register, and a
//    finished item waits until that register frees up
//  - synchronous active-high reset empties the output register and returns
//    the sequencer to idle; no other state survives between words
module ordinal_day_to_calendar_date (
   input  logic      clock,
   input  logic      reset,
   odc_req_if.sink   req,
   odc_rsp_if.source rsp
);
   import odc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: owns the request handshake
   odc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: year carry, month split and the response register
   odc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .total_days   (req.total_days),
      .start_year   (req.start_year),
      .out_valid    (rsp.valid),
      .out_ready    (rsp.ready),
      .norm_year    (rsp.norm_year),
      .day_of_year  (rsp.day_of_year),
      .month_num    (rsp.month_num),
      .day_of_month (rsp.day_of_month),
      .leap_flag    (rsp.leap_flag)
   );

endmodule

>>> sim/ordinal_day_to_calendar_date_test.sv
// ordinal_day_to_calendar_date_test: self-checking bench for the day count to date converter
// depends on odc_pkg, the odc_req_if/odc_rsp_if interfaces and the ordinal_day_to_calendar_date rtl
// a directed table of date corners runs first, then random words, all checked in order
module ordinal_day_to_calendar_date_test;
   timeunit 1ns;
   timeprecision 1ps;

   import odc_pkg::*;

   // run shape
   localparam int unsigned NumRandom   = 1030;
   localparam int unsigned IdlePct     = 37;
   localparam int unsigned QuietFirst  = 300;     // random words with no idling on either side
   localparam int unsigned QuietLast   = 500;
   localparam int unsigned DrainAt     = 700;     // sender holds off until all dates are back
   localparam int unsigned SettleCycles = 120;
   localparam int unsigned CycleLimit  = 600000;
   localparam int unsigned MaxReports  = 40;

   // month lengths, february index 1 gets one more day in leap years
   localparam int unsigned FebIndex   = 1;
   localparam int unsigned LastMonIdx = 11;
   localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [YearW-1:0] year;
      logic [DoyW-1:0]  doy;
      logic [MonW-1:0]  month;
      logic [DomW-1:0]  dom;
      logic             leap;
   } calendar_date_type;

   // one directed word; want is only used when typed is set, else the predictor decides
   typedef struct packed {
      logic [DaysW-1:0]  days;
      logic [YearW-1:0]  year;
      logic              typed;
      calendar_date_type want;
   } date_case_type;

   localparam int unsigned NumDirected = 22;
   localparam date_case_type DirectedCases [NumDirected] = '{
      // first day of a leap year
      '{15'd1,     14'd2000,  1'b1, '{14'd2000,  9'd1,   4'd1,  5'd1,  1'b1}},
      // zero count: nothing carried, day of year and day of month stay at zero
      '{15'd0,     14'd2000,  1'b1, '{14'd2000,  9'd0,   4'd1,  5'd0,  1'b1}},
      '{15'd0,     14'd16383, 1'b1, '{14'd16383, 9'd0,   4'd1,  5'd0,  1'b0}},
      // february 29 against march 1
      '{15'd60,    14'd2000,  1'b1, '{14'd2000,  9'd60,  4'd2,  5'd29, 1'b1}},
      '{15'd60,    14'd2001,  1'b1, '{14'd2001,  9'd60,  4'd3,  5'd1,  1'b0}},
      // century rule: 2100 is common, 2400 is leap
      '{15'd59,    14'd2100,  1'b1, '{14'd2100,  9'd59,  4'd2,  5'd28, 1'b0}},
      '{15'd60,    14'd2400,  1'b1, '{14'd2400,  9'd60,  4'd2,  5'd29, 1'b1}},
      // last day of the year, then one day past it
      '{15'd366,   14'd2000,  1'b1, '{14'd2000,  9'd366, 4'd12, 5'd31, 1'b1}},
      '{15'd367,   14'd2000,  1'b1, '{14'd2001,  9'd1,   4'd1,  5'd1,  1'b0}},
      '{15'd365,   14'd1900,  1'b1, '{14'd1900,  9'd365, 4'd12, 5'd31, 1'b0}},
      '{15'd366,   14'd1900,  1'b1, '{14'd1901,  9'd1,   4'd1,  5'd1,  1'b0}},
      // year zero counts as leap
      '{15'd1,     14'd0,     1'b1, '{14'd0,     9'd1,   4'd1,  5'd1,  1'b1}},
      // top of the year counter, and the wrap to year zero
      '{15'd1,     14'd16383, 1'b1, '{14'd16383, 9'd1,   4'd1,  5'd1,  1'b0}},
      '{15'd366,   14'd16383, 1'b1, '{14'd0,     9'd1,   4'd1,  5'd1,  1'b1}},
      '{15'd1,     14'd9999,  1'b1, '{14'd9999,  9'd1,   4'd1,  5'd1,  1'b0}},
      '{15'd335,   14'd2024,  1'b1, '{14'd2024,  9'd335, 4'd11, 5'd30, 1'b1}},
      // longest counts and a 10000-day count, left to the predictor
      '{15'd32767, 14'd0,     1'b0, '0},
      '{15'd32767, 14'd9999,  1'b0, '0},
      '{15'd32767, 14'd16383, 1'b0, '0},
      '{15'd32767, 14'd16300, 1'b0, '0},
      '{15'd32767, 14'd10000, 1'b0, '0},
      '{15'd10000, 14'd1999,  1'b0, '0}
   };

   logic clock;
   logic reset = 1'b1;

   odc_req_if req_ch ();
   odc_rsp_if rsp_ch ();

   ordinal_day_to_calendar_date i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   calendar_date_type pending_dates [$];   // dates owed by the block, oldest first
   int unsigned    error_count = 0;
   int unsigned    result_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    req_idle_pct = IdlePct;
   int unsigned    rsp_idle_pct = IdlePct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // gregorian leap rule on the (possibly wrapped) 14-bit year
   function automatic logic is_leap_year(input logic [YearW-1:0] yr);
      int unsigned v;
      v = 32'(yr);
      return (v % 4 == 0) && ((v % 100 != 0) || (v % 400 == 0));
   endfunction

   // carry whole years out of the count, then walk the months
   function automatic calendar_date_type ordinal_to_date(input logic [DaysW-1:0] days,
                                                         input logic [YearW-1:0] start_year);
      int unsigned       left;
      int unsigned       ylen;
      int unsigned       mon;
      int unsigned       mlen;
      logic [YearW-1:0]  yr;
      logic              lp;
      calendar_date_type d;
      left = 32'(days);
      yr   = start_year;
      ylen = is_leap_year(yr) ? 366 : 365;
      while (left > ylen) begin
         left = left - ylen;
         yr   = yr + 1'b1;     // the year counter wraps at 14 bits
         ylen = is_leap_year(yr) ? 366 : 365;
      end
      d.doy = DoyW'(left);
      lp  = is_leap_year(yr);
      mon = 0;
      mlen = DaysInMonth[0];
      while (mon < LastMonIdx && left > mlen) begin
         left = left - mlen;
         mon  = mon + 1;
         mlen = (mon == FebIndex && lp) ? DaysInMonth[mon] + 1 : DaysInMonth[mon];
      end
      d.year  = yr;
      d.month = MonW'(mon + 1);
      d.dom   = DomW'(left);
      d.leap  = lp;
      return d;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MaxReports) begin
         $display("[%0t] error: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
         report_error($sformatf("result %0d %s: got %0d, expected %0d", result_count, name, got,
                                want));
      end
   endtask

   // present one word, hold it until the block takes it, then book the expected date
   task automatic send_word(input logic [DaysW-1:0] days, input logic [YearW-1:0] year,
                            input logic typed, input calendar_date_type want);
      calendar_date_type owed;
      // random idle cycles ahead of the word
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.total_days <= days;
      req_ch.start_year <= year;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      owed = typed ? want : ordinal_to_date(days, year);
      pending_dates.push_back(owed);
   endtask

   // sender stands still until every owed date has come back
   task automatic drain_pending;
      req_ch.valid <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // response side: random back-pressure and in-order comparison
   always @(posedge clock) begin : rsp_side
      calendar_date_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_dates.size() == 0) begin
            report_error($sformatf("unexpected result: year %0d day %0d", rsp_ch.norm_year,
                                   rsp_ch.day_of_year));
         end else begin
            want = pending_dates.pop_front();
            check_field("norm_year",    16'(rsp_ch.norm_year),    16'(want.year));
            check_field("day_of_year",  16'(rsp_ch.day_of_year),  16'(want.doy));
            check_field("month_num",    16'(rsp_ch.month_num),    16'(want.month));
            check_field("day_of_month", 16'(rsp_ch.day_of_month), 16'(want.dom));
            check_field("leap_flag",    16'(rsp_ch.leap_flag),    16'(want.leap));
         end
         result_count++;
      end
      rsp_ch.ready <= (rsp_idle_pct == 0) || ($urandom_range(99) >= rsp_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("ordinal_day_to_calendar_date_test failed");
         $finish;
      end
   end

   initial begin
      int unsigned      n;
      int unsigned      sel;
      logic [DaysW-1:0] days;
      logic [YearW-1:0] year;

      req_ch.valid      = 1'b0;
      req_ch.total_days = '0;
      req_ch.start_year = '0;
      rsp_ch.ready      = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      for (n = 0; n < NumDirected; n++) begin
         send_word(DirectedCases[n].days, DirectedCases[n].year, DirectedCases[n].typed,
                   DirectedCases[n].want);
      end
      drain_pending();

      // random words: mostly in-range dates, some short counts, some years past 9999
      for (n = 0; n < NumRandom; n++) begin
         req_idle_pct = (n >= QuietFirst && n < QuietLast) ? 0 : IdlePct;
         rsp_idle_pct = req_idle_pct;
         if (n == DrainAt) begin
            drain_pending();
         end
         sel = $urandom_range(99);
         if (sel < 15) begin
            days = DaysW'($urandom_range(400));        // at most 400 days, so at most one year is carried
         end else if (sel < 25) begin
            days = DaysW'($urandom_range(2000));
         end else begin
            days = DaysW'($urandom_range(32767));
         end
         sel = $urandom_range(99);
         if (sel < 70) begin
            year = YearW'($urandom_range(9999));
         end else if (sel < 82) begin
            year = YearW'($urandom_range(2410, 1890));  // century and 400-year turns
         end else begin
            year = YearW'($urandom_range(16383, 10000)); // above range, may wrap
         end
         send_word(days, year, 1'b0, '0);
      end

      req_idle_pct = IdlePct;
      rsp_idle_pct = IdlePct;
      drain_pending();
      // let any stray word show up
      repeat (SettleCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("ordinal_day_to_calendar_date_test passed");
      end else begin
         $display("ordinal_day_to_calendar_date_test failed");
      end
      $finish;
   end

endmodule
